>>> sv/box_filter_image_downscaler_core_assert.svh
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_CORE_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_CORE_ASSERT_SVH

// same-cycle implication
`define BFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bfd_pkg.sv
package bfd_pkg;

    localparam int SRC_DIM_W      = 13;
    localparam int DST_DIM_W      = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 4;
    localparam int SUM_W          = 32;
    localparam int DEST_ROW_LIMIT = 1024;

    localparam int DEF_MAX_SRC_WIDTH  = 4096;
    localparam int DEF_MAX_SRC_HEIGHT = 4096;
    localparam int DEF_MAX_DST_WIDTH  = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic first;
        logic last;
        logic row_end;
        logic frame_end;
    } t_flags;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_pix;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  t_sums;

endpackage

>>> sv/box_filter_image_downscaler_core.sv
// box filter downscaler for an rgba pixel stream in raster order
// input channel: i_in_valid / o_in_stall, one source pixel per beat
// output channel: o_out_valid / i_out_stall, one destination pixel per beat,
//   with o_row_end and o_frame_end on the last pixel of a row and of the image
// config channel: i_cfg_valid / o_cfg_ready, always ready; index 0..3 selects
//   source width, source height, destination width, destination height
// a pixel that does not close a box is taken every cycle while setup is done and
//   the divider is idle; the column sums live in one ram, read as the pixel is taken,
//   with a bypass for back-to-back hits; a pixel that closes a box holds off the
//   next one through the ram read-modify-write and box area multiply, the shared
//   bit-serial mean divider, and the hand-off of the mean to the output register
// after reset, and after every config write, the box step sizes are worked out
//   by a bit-serial divider while o_in_stall is high; the frame position goes
//   back to the top-left pixel
// a stalled output beat holds in the output register; the divider keeps the
//   next result and input is held off until it can move on
module box_filter_image_downscaler_core #(
    parameter int MAX_SRC_WIDTH  = bfd_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bfd_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_WIDTH  = bfd_pkg::DEF_MAX_DST_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_in_red,
    input  logic [7:0]                     i_in_green,
    input  logic [7:0]                     i_in_blue,
    input  logic [7:0]                     i_in_alpha,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_red,
    output logic [7:0]                     o_out_green,
    output logic [7:0]                     o_out_blue,
    output logic [7:0]                     o_out_alpha,
    output logic                           o_row_end,
    output logic                           o_frame_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int RW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int IW    = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int CNT_W = CW + RW;
    localparam int MW    = bfd_pkg::NUM_CHAN * bfd_pkg::SUM_W;

    logic            g_ready;
    logic [IW-1:0]   g_idx;
    logic [CW-1:0]   g_box_w;
    logic [RW-1:0]   g_box_h;
    bfd_pkg::t_flags g_flags;

    logic            acc_in, cfg_we;
    logic            div_busy, div_valid, div_take;
    bfd_pkg::t_pix   div_mean;
    bfd_pkg::t_flags div_flags;

    logic            r_s1_v;
    bfd_pkg::t_pix   r_s1_pix;
    logic [IW-1:0]   r_s1_idx;
    logic [CW-1:0]   r_s1_bw;
    logic [RW-1:0]   r_s1_bh;
    bfd_pkg::t_flags r_s1_flags;

    logic            r_fw_v;
    logic [IW-1:0]   r_fw_idx;
    bfd_pkg::t_sums  r_fw_data;

    logic [MW-1:0]   ram_rdata;
    bfd_pkg::t_sums  base, sums;

    logic            r_out_v, n_out_v;
    bfd_pkg::t_pix   r_out_pix;
    bfd_pkg::t_flags r_out_flags;

    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !g_ready || (r_s1_v && r_s1_flags.last) || div_busy;
    assign acc_in      = i_in_valid && !o_in_stall;

    bfd_geom #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_WIDTH  (MAX_DST_WIDTH)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (acc_in),
        .o_ready     (g_ready),
        .o_idx       (g_idx),
        .o_box_w     (g_box_w),
        .o_box_h     (g_box_h),
        .o_flags     (g_flags)
    );

    bfd_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_DST_WIDTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_idx),
        .i_wdata (sums),
        .i_re    (acc_in),
        .i_raddr (g_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fw_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= acc_in;
            r_fw_v  <= r_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_pix   <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
            r_s1_idx   <= g_idx;
            r_s1_bw    <= g_box_w;
            r_s1_bh    <= g_box_h;
            r_s1_flags <= g_flags;
        end
        r_fw_idx  <= r_s1_idx;
        r_fw_data <= sums;
        if (div_take) begin
            r_out_pix   <= div_mean;
            r_out_flags <= div_flags;
        end
    end

    // the entry written last cycle is not yet visible at the ram read port
    always_comb begin
        if (r_s1_flags.first) begin
            base = '0;
        end else if (r_fw_v && (r_fw_idx == r_s1_idx)) begin
            base = r_fw_data;
        end else begin
            base = bfd_pkg::t_sums'(ram_rdata);
        end
        for (int ch = 0; ch < bfd_pkg::NUM_CHAN; ch++) begin
            sums[ch] = base[ch] + bfd_pkg::SUM_W'(r_s1_pix[ch]);
        end
    end

    bfd_mean_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_s1_v && r_s1_flags.last),
        .i_sums  (sums),
        .i_cnt   (CNT_W'(r_s1_bw) * CNT_W'(r_s1_bh)),
        .i_flags (r_s1_flags),
        .o_busy  (div_busy),
        .o_valid (div_valid),
        .i_take  (div_take),
        .o_mean  (div_mean),
        .o_flags (div_flags)
    );

    assign div_take = div_valid && (!r_out_v || !i_out_stall);
    assign n_out_v  = div_take || (r_out_v && i_out_stall);

    assign o_out_valid = r_out_v;
    assign o_out_red   = r_out_pix[0];
    assign o_out_green = r_out_pix[1];
    assign o_out_blue  = r_out_pix[2];
    assign o_out_alpha = r_out_pix[3];
    assign o_row_end   = r_out_flags.row_end;
    assign o_frame_end = r_out_flags.frame_end;

endmodule

>>> sv/bfd_ram.sv
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bfd_geom.sv
module bfd_geom #(
    parameter int MAX_SRC_WIDTH  = bfd_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bfd_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_WIDTH  = bfd_pkg::DEF_MAX_DST_WIDTH,
    localparam int CW  = $clog2(MAX_SRC_WIDTH + 1),
    localparam int RW  = $clog2(MAX_SRC_HEIGHT + 1),
    localparam int IW  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_step,
    output logic                             o_ready,
    output logic [IW-1:0]                    o_idx,
    output logic [CW-1:0]                    o_box_w,
    output logic [RW-1:0]                    o_box_h,
    output bfd_pkg::t_flags                  o_flags
);

    localparam int DCW  = $clog2(MAX_DST_WIDTH + 1);
    localparam int DRW  = $clog2(bfd_pkg::DEST_ROW_LIMIT + 1);
    localparam int SU_W = (CW > RW) ? CW : RW;
    localparam int SCW  = $clog2(SU_W + 1);

    logic [bfd_pkg::SRC_DIM_W-1:0] r_sw_raw, r_sh_raw;
    logic [bfd_pkg::DST_DIM_W-1:0] r_dw_raw, r_dh_raw;

    logic [CW-1:0]  eff_sw;
    logic [RW-1:0]  eff_sh;
    logic [DCW-1:0] eff_dw;
    logic [DRW-1:0] eff_dh;
    logic [31:0]    lim_w, lim_h;

    always_comb begin
        if (r_sw_raw == '0) begin
            eff_sw = CW'(1);
        end else if (32'(r_sw_raw) > 32'(MAX_SRC_WIDTH)) begin
            eff_sw = CW'(MAX_SRC_WIDTH);
        end else begin
            eff_sw = CW'(r_sw_raw);
        end
        if (r_sh_raw == '0) begin
            eff_sh = RW'(1);
        end else if (32'(r_sh_raw) > 32'(MAX_SRC_HEIGHT)) begin
            eff_sh = RW'(MAX_SRC_HEIGHT);
        end else begin
            eff_sh = RW'(r_sh_raw);
        end
        lim_w = (32'(eff_sw) < 32'(MAX_DST_WIDTH)) ? 32'(eff_sw) : 32'(MAX_DST_WIDTH);
        lim_h = (32'(eff_sh) < 32'(bfd_pkg::DEST_ROW_LIMIT)) ? 32'(eff_sh)
                                                             : 32'(bfd_pkg::DEST_ROW_LIMIT);
        if (r_dw_raw == '0) begin
            eff_dw = DCW'(1);
        end else if (32'(r_dw_raw) > lim_w) begin
            eff_dw = DCW'(lim_w);
        end else begin
            eff_dw = DCW'(r_dw_raw);
        end
        if (r_dh_raw == '0) begin
            eff_dh = DRW'(1);
        end else if (32'(r_dh_raw) > lim_h) begin
            eff_dh = DRW'(lim_h);
        end else begin
            eff_dh = DRW'(r_dh_raw);
        end
    end

    // setup: long division of source by destination size, one bit a cycle
    logic            r_su_pend, r_su_run;
    logic [SCW-1:0]  r_su_cnt;
    logic [SU_W-1:0] r_dvc, r_dvr, r_su_qc, r_su_qr;
    logic [DCW-1:0]  r_su_rc;
    logic [DRW-1:0]  r_su_rr;
    logic [DCW:0]    su_tc;
    logic [DRW:0]    su_tr;
    logic            su_bc, su_br;
    logic [SU_W-1:0] n_su_qc, n_su_qr;
    logic [DCW-1:0]  n_su_rc;
    logic [DRW-1:0]  n_su_rr;

    always_comb begin
        su_tc   = {r_su_rc, r_dvc[SU_W-1]};
        su_tr   = {r_su_rr, r_dvr[SU_W-1]};
        su_bc   = su_tc >= (DCW+1)'(eff_dw);
        su_br   = su_tr >= (DRW+1)'(eff_dh);
        n_su_rc = su_bc ? DCW'(su_tc - (DCW+1)'(eff_dw)) : DCW'(su_tc);
        n_su_rr = su_br ? DRW'(su_tr - (DRW+1)'(eff_dh)) : DRW'(su_tr);
        n_su_qc = (r_su_qc << 1) | SU_W'(su_bc);
        n_su_qr = (r_su_qr << 1) | SU_W'(su_br);
    end

    // frame position and box bounds
    logic [CW-1:0]  r_sc, r_cbs, r_cbe, r_qc;
    logic [RW-1:0]  r_sr, r_rbs, r_rbe, r_qr;
    logic [DCW-1:0] r_dc, r_crem, r_rc;
    logic [DRW-1:0] r_dr, r_rrem, r_rr;

    logic           last_col, last_row, dc_last, dr_last;
    logic [DCW:0]   csum;
    logic [DRW:0]   rsum;
    logic           cwrap, rwrap;
    logic [CW-1:0]  n_cbe;
    logic [RW-1:0]  n_rbe;
    logic [DCW-1:0] n_crem;
    logic [DRW-1:0] n_rrem;

    always_comb begin
        last_col = (CW+1)'(r_sc) + 1'b1 >= (CW+1)'(r_cbe);
        last_row = (RW+1)'(r_sr) + 1'b1 >= (RW+1)'(r_rbe);
        dc_last  = (DCW+1)'(r_dc) + 1'b1 >= (DCW+1)'(eff_dw);
        dr_last  = (DRW+1)'(r_dr) + 1'b1 >= (DRW+1)'(eff_dh);
        csum     = (DCW+1)'(r_crem) + (DCW+1)'(r_rc);
        rsum     = (DRW+1)'(r_rrem) + (DRW+1)'(r_rr);
        cwrap    = csum >= (DCW+1)'(eff_dw);
        rwrap    = rsum >= (DRW+1)'(eff_dh);
        n_cbe    = r_cbe + r_qc + CW'(cwrap);
        n_rbe    = r_rbe + r_qr + RW'(rwrap);
        n_crem   = cwrap ? DCW'(csum - (DCW+1)'(eff_dw)) : DCW'(csum);
        n_rrem   = rwrap ? DRW'(rsum - (DRW+1)'(eff_dh)) : DRW'(rsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_raw  <= bfd_pkg::SRC_DIM_W'(1);
            r_sh_raw  <= bfd_pkg::SRC_DIM_W'(1);
            r_dw_raw  <= bfd_pkg::DST_DIM_W'(1);
            r_dh_raw  <= bfd_pkg::DST_DIM_W'(1);
            r_su_pend <= 1'b1;
            r_su_run  <= 1'b0;
            r_su_cnt  <= '0;
            r_sc      <= '0;
            r_sr      <= '0;
            r_dc      <= '0;
            r_dr      <= '0;
            r_cbs     <= '0;
            r_rbs     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bfd_pkg::REG_SRC_WIDTH:  r_sw_raw <= i_cfg_data;
                bfd_pkg::REG_SRC_HEIGHT: r_sh_raw <= i_cfg_data;
                bfd_pkg::REG_DST_WIDTH:  r_dw_raw <= bfd_pkg::DST_DIM_W'(i_cfg_data);
                bfd_pkg::REG_DST_HEIGHT: r_dh_raw <= bfd_pkg::DST_DIM_W'(i_cfg_data);
                default: ;
            endcase
            r_su_pend <= 1'b1;
            r_su_run  <= 1'b0;
            r_sc      <= '0;
            r_sr      <= '0;
            r_dc      <= '0;
            r_dr      <= '0;
            r_cbs     <= '0;
            r_rbs     <= '0;
        end else if (r_su_pend) begin
            r_su_pend <= 1'b0;
            r_su_run  <= 1'b1;
            r_su_cnt  <= SCW'(SU_W);
            r_dvc     <= SU_W'(eff_sw);
            r_dvr     <= SU_W'(eff_sh);
            r_su_qc   <= '0;
            r_su_qr   <= '0;
            r_su_rc   <= '0;
            r_su_rr   <= '0;
        end else if (r_su_run) begin
            r_dvc    <= r_dvc << 1;
            r_dvr    <= r_dvr << 1;
            r_su_qc  <= n_su_qc;
            r_su_qr  <= n_su_qr;
            r_su_rc  <= n_su_rc;
            r_su_rr  <= n_su_rr;
            r_su_cnt <= r_su_cnt - 1'b1;
            if (r_su_cnt == SCW'(1)) begin
                r_su_run <= 1'b0;
                r_qc     <= CW'(n_su_qc);
                r_qr     <= RW'(n_su_qr);
                r_rc     <= n_su_rc;
                r_rr     <= n_su_rr;
                r_cbe    <= CW'(n_su_qc);
                r_rbe    <= RW'(n_su_qr);
                r_crem   <= n_su_rc;
                r_rrem   <= n_su_rr;
            end
        end else if (i_step) begin
            if (!last_col) begin
                r_sc <= r_sc + 1'b1;
            end else if (!dc_last) begin
                r_sc   <= r_sc + 1'b1;
                r_dc   <= r_dc + 1'b1;
                r_cbs  <= r_cbe;
                r_cbe  <= n_cbe;
                r_crem <= n_crem;
            end else begin
                // end of a source row
                r_sc   <= '0;
                r_dc   <= '0;
                r_cbs  <= '0;
                r_cbe  <= r_qc;
                r_crem <= r_rc;
                if (!last_row) begin
                    r_sr <= r_sr + 1'b1;
                end else if (!dr_last) begin
                    r_sr   <= r_sr + 1'b1;
                    r_dr   <= r_dr + 1'b1;
                    r_rbs  <= r_rbe;
                    r_rbe  <= n_rbe;
                    r_rrem <= n_rrem;
                end else begin
                    r_sr   <= '0;
                    r_dr   <= '0;
                    r_rbs  <= '0;
                    r_rbe  <= r_qr;
                    r_rrem <= r_rr;
                end
            end
        end
    end

    assign o_ready           = !r_su_pend && !r_su_run;
    assign o_idx             = IW'(r_dc);
    assign o_box_w           = r_cbe - r_cbs;
    assign o_box_h           = r_rbe - r_rbs;
    assign o_flags.first     = (r_sr == r_rbs) && (r_sc == r_cbs);
    assign o_flags.last      = last_col && last_row;
    assign o_flags.row_end   = dc_last;
    assign o_flags.frame_end = dc_last && dr_last;

endmodule

>>> sv/bfd_mean_div.sv
module bfd_mean_div #(
    parameter int CNT_W = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  bfd_pkg::t_sums       i_sums,
    input  logic [CNT_W-1:0]     i_cnt,
    input  bfd_pkg::t_flags      i_flags,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_take,
    output bfd_pkg::t_pix        o_mean,
    output bfd_pkg::t_flags      o_flags
);

    localparam int XW = (bfd_pkg::SUM_W > CNT_W + bfd_pkg::CHAN_W) ? bfd_pkg::SUM_W
                                                                    : CNT_W + bfd_pkg::CHAN_W;
    localparam int BW = $clog2(bfd_pkg::CHAN_W);

    logic                   r_run, r_done;
    logic [BW-1:0]          r_bit;
    logic [CNT_W-1:0]       r_cnt;
    bfd_pkg::t_sums         r_rem, n_rem;
    bfd_pkg::t_pix          r_q, n_q;
    bfd_pkg::t_flags        r_flags;
    logic [XW-1:0]          shifted;

    // restoring division, one quotient bit per cycle for all channels
    always_comb begin
        shifted = XW'(r_cnt) << r_bit;
        n_rem   = r_rem;
        n_q     = r_q;
        for (int ch = 0; ch < bfd_pkg::NUM_CHAN; ch++) begin
            if (XW'(r_rem[ch]) >= shifted) begin
                n_rem[ch]       = bfd_pkg::SUM_W'(XW'(r_rem[ch]) - shifted);
                n_q[ch][r_bit]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_run   <= 1'b1;
            r_done  <= 1'b0;
            r_bit   <= BW'(bfd_pkg::CHAN_W - 1);
            r_rem   <= i_sums;
            r_cnt   <= i_cnt;
            r_q     <= '0;
            r_flags <= i_flags;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_bit <= r_bit - 1'b1;
            if (r_bit == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done && i_take) begin
            r_done <= 1'b0;
        end
    end

    assign o_busy  = r_run || r_done;
    assign o_valid = r_done;
    assign o_mean  = r_q;
    assign o_flags = r_flags;

endmodule

>>> sv/bfd_checker.sv
`include "box_filter_image_downscaler_core_assert.svh"

module bfd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [7:0]                     o_out_red,
    input logic [7:0]                     o_out_green,
    input logic [7:0]                     o_out_blue,
    input logic [7:0]                     o_out_alpha,
    input logic                           o_row_end,
    input logic                           o_frame_end,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    // a stalled result beat holds
    `BFD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha) && $stable(o_row_end) && $stable(o_frame_end),
        "stalled output beat changed")

    // the last pixel of the image is also the last of its row
    `BFD_ASSERT_NOW(a_frame_row, o_out_valid && o_frame_end, o_row_end,
        "frame end without row end")

    // a config write restarts box setup, so input is held off next cycle
    `BFD_ASSERT_NEXT(a_cfg_setup, i_cfg_valid && o_cfg_ready, o_in_stall,
        "input not held off during box setup")

    // a freshly shown result comes from the divider, never straight after input
    `BFD_ASSERT_NOW(a_out_latency, $rose(o_out_valid),
        $past(o_in_stall, 1) && $past(o_in_stall, 2),
        "result appeared without divider latency")

endmodule

bind box_filter_image_downscaler_core bfd_checker u_bfd_checker (.*);

>>> tb/box_filter_image_downscaler_core_checker.sv
module box_filter_image_downscaler_core_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_in_red,
    input  logic [7:0]                     i_in_green,
    input  logic [7:0]                     i_in_blue,
    input  logic [7:0]                     i_in_alpha,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     i_out_red,
    input  logic [7:0]                     i_out_green,
    input  logic [7:0]                     i_out_blue,
    input  logic [7:0]                     i_out_alpha,
    input  logic                           i_row_end,
    input  logic                           i_frame_end,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending_count,
    output int                             o_checked_count
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       frame_end;
    } t_mean_pix;

    t_mean_pix box_means_q[$];

    logic [bfd_pkg::SRC_DIM_W-1:0] src_w_reg, src_h_reg;
    logic [bfd_pkg::DST_DIM_W-1:0] dst_w_reg, dst_h_reg;
    logic [31:0] col_sum [0:bfd_pkg::DEF_MAX_DST_WIDTH-1][0:3];
    int unsigned src_col, src_row, dst_col, dst_row;
    int unsigned col_lo, col_hi, row_lo, row_hi;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned src_w_eff();
        return clamp_dim(src_w_reg, bfd_pkg::DEF_MAX_SRC_WIDTH);
    endfunction

    function automatic int unsigned src_h_eff();
        return clamp_dim(src_h_reg, bfd_pkg::DEF_MAX_SRC_HEIGHT);
    endfunction

    function automatic int unsigned dst_w_eff();
        int unsigned sw;
        sw = src_w_eff();
        return clamp_dim(dst_w_reg, sw < bfd_pkg::DEF_MAX_DST_WIDTH ? sw
                                                                    : bfd_pkg::DEF_MAX_DST_WIDTH);
    endfunction

    function automatic int unsigned dst_h_eff();
        int unsigned sh;
        sh = src_h_eff();
        return clamp_dim(dst_h_reg, sh < bfd_pkg::DEST_ROW_LIMIT ? sh
                                                                 : bfd_pkg::DEST_ROW_LIMIT);
    endfunction

    // exclusive end of box k
    function automatic int unsigned box_limit(int unsigned k, int unsigned s, int unsigned d);
        longint unsigned p;
        p = longint'(k + 1) * s;
        return int'(p / d);
    endfunction

    task automatic frame_restart();
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_lo = 0;
        row_lo = 0;
        col_hi = box_limit(0, src_w_eff(), dst_w_eff());
        row_hi = box_limit(0, src_h_eff(), dst_h_eff());
    endtask

    task automatic accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] a);
        int unsigned sw, sh, dw, dh, ix;
        logic [7:0] px [0:3];
        bit at_col_end, at_row_end;
        longint unsigned area;
        t_mean_pix m;
        sw = src_w_eff();
        sh = src_h_eff();
        dw = dst_w_eff();
        dh = dst_h_eff();
        px[0] = r;
        px[1] = g;
        px[2] = b;
        px[3] = a;
        ix = dst_col < bfd_pkg::DEF_MAX_DST_WIDTH ? dst_col : bfd_pkg::DEF_MAX_DST_WIDTH - 1;
        at_col_end = (src_col + 1) >= col_hi;
        at_row_end = (src_row + 1) >= row_hi;
        for (int c = 0; c < 4; c++) begin
            if (src_row == row_lo && src_col == col_lo)
                col_sum[ix][c] = px[c];
            else
                col_sum[ix][c] = col_sum[ix][c] + px[c];
        end
        if (at_col_end && at_row_end) begin
            area = longint'(col_hi - col_lo) * longint'(row_hi - row_lo);
            if (area == 0) area = 1;
            m.red       = 8'(longint'(col_sum[ix][0]) / area);
            m.green     = 8'(longint'(col_sum[ix][1]) / area);
            m.blue      = 8'(longint'(col_sum[ix][2]) / area);
            m.alpha     = 8'(longint'(col_sum[ix][3]) / area);
            m.row_end   = (dst_col + 1) >= dw;
            m.frame_end = m.row_end && (dst_row + 1) >= dh;
            box_means_q = {box_means_q, m};
        end
        if (!at_col_end) begin
            src_col++;
        end else if ((dst_col + 1) < dw) begin
            src_col++;
            dst_col++;
            col_lo = col_hi;
            col_hi = box_limit(dst_col, sw, dw);
        end else begin
            src_col = 0;
            dst_col = 0;
            col_lo = 0;
            col_hi = box_limit(0, sw, dw);
            if (!at_row_end) begin
                src_row++;
            end else if ((dst_row + 1) < dh) begin
                src_row++;
                dst_row++;
                row_lo = row_hi;
                row_hi = box_limit(dst_row, sh, dh);
            end else begin
                frame_restart();
            end
        end
    endtask

    task automatic compare_mean(t_mean_pix got);
        t_mean_pix want;
        want = box_means_q.pop_front();
        o_checked_count++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.row_end !== want.row_end ||
            got.frame_end !== want.frame_end) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display({"mismatch on result %0d: expected rgba %0d %0d %0d %0d re %0b fe %0b,",
                          " got rgba %0d %0d %0d %0d re %0b fe %0b"},
                         o_checked_count, want.red, want.green, want.blue, want.alpha,
                         want.row_end, want.frame_end, got.red, got.green, got.blue,
                         got.alpha, got.row_end, got.frame_end);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked_count = 0;
        o_pending_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_means_q.delete();
            src_w_reg = 1;
            src_h_reg = 1;
            dst_w_reg = 1;
            dst_h_reg = 1;
            frame_restart();
        end else begin
            // drain first: a result can never belong to a pixel taken on this edge
            if (i_out_valid && !i_out_stall) begin
                if (box_means_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: rgba %0d %0d %0d %0d re %0b fe %0b",
                                 i_out_red, i_out_green, i_out_blue, i_out_alpha,
                                 i_row_end, i_frame_end);
                end else begin
                    compare_mean({i_out_red, i_out_green, i_out_blue, i_out_alpha,
                                  i_row_end, i_frame_end});
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    bfd_pkg::REG_SRC_WIDTH:  src_w_reg = i_cfg_data;
                    bfd_pkg::REG_SRC_HEIGHT: src_h_reg = i_cfg_data;
                    bfd_pkg::REG_DST_WIDTH:  dst_w_reg = i_cfg_data[bfd_pkg::DST_DIM_W-1:0];
                    bfd_pkg::REG_DST_HEIGHT: dst_h_reg = i_cfg_data[bfd_pkg::DST_DIM_W-1:0];
                    default: ;
                endcase
                frame_restart();
            end
            if (i_in_valid && !i_in_stall)
                accumulate_pixel(i_in_red, i_in_green, i_in_blue, i_in_alpha);
        end
        o_pending_count = box_means_q.size();
    end

endmodule

>>> tb/box_filter_image_downscaler_core_test.sv
module box_filter_image_downscaler_core_test;

    localparam int IDLE_LIMIT = 20000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [7:0]                     i_in_red, i_in_green, i_in_blue, i_in_alpha;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [7:0]                     o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                           o_row_end, o_frame_end;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int fail_count, pending_count, checked_count;
    logic pixel_taken, cfg_taken;
    bit quiet;
    int sent_pixels, phase_count, idle_cycles, stall_left;

    box_filter_image_downscaler_core dut (.*);

    box_filter_image_downscaler_core_checker mon (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_in_red(i_in_red), .i_in_green(i_in_green),
        .i_in_blue(i_in_blue), .i_in_alpha(i_in_alpha),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_out_red(o_out_red), .i_out_green(o_out_green),
        .i_out_blue(o_out_blue), .i_out_alpha(o_out_alpha),
        .i_row_end(o_row_end), .i_frame_end(o_frame_end),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending_count(pending_count),
        .o_checked_count(checked_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pixel_taken <= i_in_valid && !o_in_stall;
        cfg_taken   <= i_cfg_valid && o_cfg_ready;
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("box_filter_image_downscaler_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] channel_value();
        unique case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_red   = r;
        i_in_green = g;
        i_in_blue  = b;
        i_in_alpha = a;
        do @(negedge i_clk); while (!pixel_taken);
        i_in_valid = 1'b0;
        sent_pixels++;
    endtask

    task automatic send_random_pixels(int count);
        repeat (count) send_pixel(channel_value(), channel_value(), channel_value(),
                                  channel_value());
    endtask

    task automatic write_reg(logic [bfd_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = bfd_pkg::CFG_DATA_W'(value);
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    // let the block settle before touching registers
    task automatic drain_results();
        while (pending_count != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh);
        drain_results();
        write_reg(bfd_pkg::REG_SRC_WIDTH, sw);
        write_reg(bfd_pkg::REG_SRC_HEIGHT, sh);
        write_reg(bfd_pkg::REG_DST_WIDTH, dw);
        write_reg(bfd_pkg::REG_DST_HEIGHT, dh);
        phase_count++;
    endtask

    initial begin
        int unsigned sw, sh, dw, dh, frame_px, burst;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_red    = '0;
        i_in_green  = '0;
        i_in_blue   = '0;
        i_in_alpha  = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bfd_pkg::REG_SRC_WIDTH;
        i_cfg_data  = '0;
        stall_left  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        sent_pixels = 0;
        phase_count = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset sizes: every pixel is its own box
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0);
        // uneven boxes, destination wider than source gets clamped
        set_sizes(3, 2, 2, 1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
        send_random_pixels(3);
        set_sizes(2, 2, 5, 7);
        send_random_pixels(5);
        // partial frame dropped by the following write
        set_sizes(5, 5, 2, 2);
        send_random_pixels(6);

        // extremes: zero sizes clamp up, oversize ones clamp down
        set_sizes(0, 8191, 0, 2047);
        send_random_pixels(64);
        set_sizes(8191, 0, 2047, 0);
        send_random_pixels(64);

        while (sent_pixels < 1400) begin
            sw = $urandom_range(1, 24);
            sh = $urandom_range(1, 10);
            dw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(1, sw);
            dh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, sh);
            set_sizes(sw, sh, dw, dh);
            frame_px = sw * sh;
            if (sent_pixels > 1100) quiet = 1'b1;
            if ($urandom_range(0, 4) == 0)
                burst = $urandom_range(1, frame_px);
            else
                burst = frame_px * $urandom_range(1, 3);
            if (burst > 1400 - sent_pixels) burst = 1400 - sent_pixels;
            send_random_pixels(burst);
        end

        while (pending_count != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("ran %0d size settings over %0d pixels, with clamped sizes,",
                 phase_count, sent_pixels);
        $display("uneven boxes and stalls; %0d box means compared", checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("box_filter_image_downscaler_core test passed");
        end else begin
            $display("box_filter_image_downscaler_core test failed");
        end
        $finish;
    end

endmodule
